@@ hw/rtl/trq_pkg.sv @@
// Package for the trail ribbon quad generator.
// Holds the word types, register indexes and shared constants; no dependencies.
`default_nettype none
package trq_pkg;

  localparam int MaxPointsDef = 16;

  localparam logic [1:0] RegSegCount  = 2'd0;
  localparam logic [1:0] RegHalfWidth = 2'd1;
  localparam logic [1:0] RegShiftPer  = 2'd2;
  localparam logic [1:0] RegAlpha     = 2'd3;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] draw_a;
    logic signed [23:0] draw_b;
    logic signed [23:0] draw_c;
    logic signed [23:0] draw_d;
    logic signed [23:0] draw_tx;
    logic signed [23:0] draw_ty;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] near_left_x;
    logic signed [31:0] near_left_y;
    logic signed [31:0] near_right_x;
    logic signed [31:0] near_right_y;
    logic signed [31:0] far_right_x;
    logic signed [31:0] far_right_y;
    logic signed [31:0] far_left_x;
    logic signed [31:0] far_left_y;
    logic [15:0]        near_alpha;
    logic [15:0]        far_alpha;
    logic               last_quad;
  } out_word_t;

  // Configuration held by the register block.
  typedef struct packed {
    logic [4:0]  segment_count;
    logic [15:0] half_width;
    logic [7:0]  shift_period;
    logic [7:0]  color_alpha;
  } cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/trail_ribbon_quad_generator.sv @@
// Trail ribbon quad generator, top level.
// Sequence: the history update, then per point up to four uses of the bit-serial
//   root / divider unit (a root and two divides, skipped for a zero direction, and a width
//   divide for all but the last point when n > 2), then sixteen transform products per quad.
// Throughput: one frame at a time; in_ready is low from accept until the last
//   quad has been taken. Output word held in a register until taken.
// Reset: synchronous, active high; clears sequencer, frame counter, fill flag and
//   output valid; the point history is undefined until the first frame writes it.
`default_nettype none
module trail_ribbon_quad_generator #(
  parameter int MAX_POINTS = trq_pkg::MaxPointsDef
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire                 in_valid,
  output logic                in_ready,
  input  trq_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output trq_pkg::out_word_t  out_data
);
  import trq_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_HIST  = 15'b000000000000010,
    S_RD    = 15'b000000000000100,
    S_NORM  = 15'b000000000001000,
    S_SQ    = 15'b000000000010000,
    S_SQW   = 15'b000000000100000,
    S_DX    = 15'b000000001000000,
    S_DY    = 15'b000000010000000,
    S_KDIV  = 15'b000000100000000,
    S_KW    = 15'b000001000000000,
    S_EDGE  = 15'b000010000000000,
    S_STORE = 15'b000100000000000,
    S_XF    = 15'b001000000000000,
    S_XFW   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  cfg_t cfg;
  trq_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  state_t state;
  in_word_t fr;
  logic [7:0]  frame_count;
  logic        filled;
  logic [CW-1:0] n;
  logic [IW-1:0] pt;
  logic [IW-1:0] wi;
  logic [3:0]  sub;

  logic signed [23:0] hist_x [MAX_POINTS];
  logic signed [23:0] hist_y [MAX_POINTS];
  // Edge and alpha store per point.
  logic signed [25:0] lxs [MAX_POINTS];
  logic signed [25:0] lys [MAX_POINTS];
  logic signed [25:0] rxs [MAX_POINTS];
  logic signed [25:0] rys [MAX_POINTS];
  logic [15:0]        als [MAX_POINTS];

  // Effective point count.
  always_comb begin
    if (cfg.segment_count < 5'd2) n = CW'(2);
    else if (32'(cfg.segment_count) > MAX_POINTS) n = CW'(MAX_POINTS);
    else n = CW'(cfg.segment_count);
  end

  // Shared unit.
  logic        u_start, u_div, u_done;
  logic [63:0] u_num;
  logic [31:0] u_den, u_res;
  trq_isqrt u_unit (
    .clk(clk), .rst(rst), .start(u_start), .is_div(u_div), .num(u_num),
    .den(u_den), .done(u_done), .res(u_res)
  );

  // Direction working registers.
  logic signed [24:0] dx, dy;
  logic [24:0] ax, ay;
  logic [31:0] rr;
  logic [14:0] qx;
  logic [14:0] qy;
  logic [16:0] kf;
  logic [32:0] wk;
  logic signed [23:0] cx, cy;
  logic signed [48:0] prod;
  logic signed [31:0] vx, vy;

  logic [IW-1:0] lo_i, hi_i;
  logic last_pt;
  assign last_pt = (32'(pt) == 32'(n) - 1);
  assign lo_i = (pt == '0) ? '0 : pt - IW'(1);
  assign hi_i = last_pt ? pt : pt + IW'(1);

  // Shift decision: taken at point zero, held in sub[0] for the rest of the pass.
  logic shift_hit, do_shift;
  assign shift_hit = (frame_count + 8'd1 >= cfg.shift_period);
  assign do_shift  = (pt == '0) ? shift_hit : sub[0];

  // Transform multiplier: combinational product of the operands loaded in S_XF, used in S_XFW.
  logic signed [25:0] mv;
  logic signed [23:0] me;
  logic signed [50:0] acc;
  logic signed [50:0] mprod;
  assign mprod = 51'(mv) * 51'(me);

  logic [IW-1:0] jn, jf;
  assign jn = wi;
  assign jf = wi - IW'(1);

  function automatic logic signed [31:0] sat32(input logic signed [50:0] a,
                                               input logic signed [23:0] t);
    logic signed [51:0] q;
    logic signed [51:0] v;
    begin
      q = 52'(a) / 52'sd1024;
      v = q + 52'(t);
      if (v > 52'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -52'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  // Edge offset: (wk * q) >> 31, wk < 2^33, q < 2^15; one multiplier, used in turn for qx and qy.
  logic [47:0] ow;
  logic [14:0] oq;
  logic [25:0] off;
  assign ow  = 48'(wk) * 48'(oq);
  assign off = 26'(ow >> 31);
  logic signed [25:0] wxs, wys;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_count <= 8'd0;
      filled      <= 1'b0;
      out_valid   <= 1'b0;
      u_start     <= 1'b0;
    end else begin
      u_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            fr    <= in_data;
            pt    <= '0;
            state <= S_HIST;
          end
        end
        // Update one history point per cycle.
        S_HIST: begin
          if (!filled || last_pt) begin
            hist_x[pt] <= fr.pos_x;
            hist_y[pt] <= fr.pos_y;
          end else if (do_shift) begin
            hist_x[pt] <= hist_x[pt + IW'(1)];
            hist_y[pt] <= hist_y[pt + IW'(1)];
          end
          if (pt == '0 && filled) begin
            sub[0]      <= shift_hit;
            frame_count <= shift_hit ? 8'd0 : frame_count + 8'd1;
          end
          if (last_pt) begin
            filled <= 1'b1;
            pt     <= '0;
            state  <= S_RD;
          end else begin
            pt <= pt + IW'(1);
          end
        end
        // Direction difference.
        S_RD: begin
          dx <= 25'(hist_x[hi_i]) - 25'(hist_x[lo_i]);
          dy <= 25'(hist_y[hi_i]) - 25'(hist_y[lo_i]);
          ax <= (hist_x[hi_i] >= hist_x[lo_i]) ? 25'(25'(hist_x[hi_i]) - 25'(hist_x[lo_i]))
                                               : 25'(25'(hist_x[lo_i]) - 25'(hist_x[hi_i]));
          ay <= (hist_y[hi_i] >= hist_y[lo_i]) ? 25'(25'(hist_y[hi_i]) - 25'(hist_y[lo_i]))
                                               : 25'(25'(hist_y[lo_i]) - 25'(hist_y[hi_i]));
          state <= S_NORM;
        end
        // Shift magnitudes down below 2^16, one bit a cycle.
        S_NORM: begin
          if (ax[24:16] != 9'd0 || ay[24:16] != 9'd0) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else if (ax == 25'd0 && ay == 25'd0) begin
            qx <= 15'd0;
            qy <= 15'd0;
            state <= S_KDIV;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          u_num   <= (64'(ax[15:0]) * 64'(ax[15:0]) + 64'(ay[15:0]) * 64'(ay[15:0])) << 28;
          u_div   <= 1'b0;
          u_start <= 1'b1;
          state   <= S_SQW;
        end
        S_SQW: begin
          if (u_done) begin
            rr      <= u_res;
            u_num   <= 64'(ax[15:0]) << 29;
            u_den   <= u_res;
            u_div   <= 1'b1;
            u_start <= 1'b1;
            state   <= S_DX;
          end
        end
        S_DX: begin
          if (u_done) begin
            qx      <= (u_res > 32'd32767) ? 15'd32767 : u_res[14:0];
            u_num   <= 64'(ay[15:0]) << 29;
            u_den   <= rr;
            u_start <= 1'b1;
            state   <= S_DY;
          end
        end
        S_DY: begin
          if (u_done) begin
            qy    <= (u_res > 32'd32767) ? 15'd32767 : u_res[14:0];
            state <= S_KDIV;
          end
        end
        // Width factor for this point; all but the last point go through the divider when n > 2.
        S_KDIV: begin
          sub <= 4'd0;
          if (last_pt) begin
            kf    <= 17'd65536;
            state <= S_EDGE;
          end else if (n == CW'(2)) begin
            kf    <= 17'd6553;
            state <= S_EDGE;
          end else begin
            u_num   <= {32'd0, 16'(32'(n) - 32'd2 + 32'd9 * 32'(pt)), 16'd0};
            u_den   <= 32'd10 * (32'(n) - 32'd2);
            u_div   <= 1'b1;
            u_start <= 1'b1;
            state   <= S_KW;
          end
        end
        S_KW: begin
          if (u_done) begin
            kf    <= 17'(u_res);
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          case (sub)
            4'd0: begin
              wk  <= 33'(cfg.half_width) * 33'(kf);
              sub <= 4'd1;
            end
            4'd1: begin
              oq  <= qx;
              sub <= 4'd2;
            end
            4'd2: begin
              wxs <= dx[24] ? -off : off;
              oq  <= qy;
              sub <= 4'd3;
            end
            default: begin
              wys   <= dy[24] ? -off : off;
              state <= S_STORE;
            end
          endcase
        end
        S_STORE: begin
          lxs[pt] <= 26'(hist_x[pt]) - wys;
          lys[pt] <= 26'(hist_y[pt]) + wxs;
          rxs[pt] <= 26'(hist_x[pt]) + wys;
          rys[pt] <= 26'(hist_y[pt]) - wxs;
          als[pt] <= 16'((32'(cfg.color_alpha) * 32'd257 * 32'(kf)) >> 16);
          if (last_pt) begin
            wi    <= pt;
            sub   <= 4'd0;
            state <= S_XF;
          end else begin
            pt    <= pt + IW'(1);
            state <= S_RD;
          end
        end
        // Transform: two products per coordinate, 16 products per quad.
        S_XF: begin
          case (sub[3:1])
            3'd0: begin mv <= sub[0] ? lys[jn] : lxs[jn]; end
            3'd1: begin mv <= sub[0] ? lys[jn] : lxs[jn]; end
            3'd2: begin mv <= sub[0] ? rys[jn] : rxs[jn]; end
            3'd3: begin mv <= sub[0] ? rys[jn] : rxs[jn]; end
            3'd4: begin mv <= sub[0] ? rys[jf] : rxs[jf]; end
            3'd5: begin mv <= sub[0] ? rys[jf] : rxs[jf]; end
            3'd6: begin mv <= sub[0] ? lys[jf] : lxs[jf]; end
            default: begin mv <= sub[0] ? lys[jf] : lxs[jf]; end
          endcase
          if (sub[1]) me <= sub[0] ? fr.draw_d : fr.draw_b;
          else        me <= sub[0] ? fr.draw_c : fr.draw_a;
          state <= S_XFW;
        end
        S_XFW: begin
          if (!sub[0]) begin
            acc <= mprod;
          end else begin
            case (sub[3:1])
              3'd0: out_data.near_left_x  <= sat32(acc + mprod, fr.draw_tx);
              3'd1: out_data.near_left_y  <= sat32(acc + mprod, fr.draw_ty);
              3'd2: out_data.near_right_x <= sat32(acc + mprod, fr.draw_tx);
              3'd3: out_data.near_right_y <= sat32(acc + mprod, fr.draw_ty);
              3'd4: out_data.far_right_x  <= sat32(acc + mprod, fr.draw_tx);
              3'd5: out_data.far_right_y  <= sat32(acc + mprod, fr.draw_ty);
              3'd6: out_data.far_left_x   <= sat32(acc + mprod, fr.draw_tx);
              default: out_data.far_left_y <= sat32(acc + mprod, fr.draw_ty);
            endcase
          end
          if (sub == 4'd15) begin
            out_data.near_alpha <= als[jn];
            out_data.far_alpha  <= als[jf];
            out_data.last_quad  <= (wi == IW'(1));
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_XF;
          end
          sub <= sub + 4'd1;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (wi == IW'(1)) begin
              state <= S_IDLE;
            end else begin
              wi    <= wi - IW'(1);
              sub   <= 4'd0;
              state <= S_XF;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/trq_regs.sv @@
// APB register block for the trail ribbon quad generator.
// Depends on trq_pkg.
`default_nettype none
module trq_regs (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output trq_pkg::cfg_t cfg
);
  import trq_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  // Write registers on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_count <= 5'd16;
      cfg.half_width    <= 16'd256;
      cfg.shift_period  <= 8'd1;
      cfg.color_alpha   <= 8'd255;
    end else if (wr) begin
      case (idx)
        RegSegCount:  cfg.segment_count <= pwdata[4:0];
        RegHalfWidth: cfg.half_width    <= pwdata[15:0];
        RegShiftPer:  cfg.shift_period  <= pwdata[7:0];
        RegAlpha:     cfg.color_alpha   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      RegSegCount:  prdata = {27'd0, cfg.segment_count};
      RegHalfWidth: prdata = {16'd0, cfg.half_width};
      RegShiftPer:  prdata = {24'd0, cfg.shift_period};
      RegAlpha:     prdata = {24'd0, cfg.color_alpha};
      default:      prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/trq_isqrt.sv @@
// Iterative square root and divider used for direction normalization and the width factor.
// One result bit per cycle; depends on nothing.
`default_nettype none
module trq_isqrt (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire         is_div,
  input  wire  [63:0] num,
  input  wire  [31:0] den,
  output logic        done,
  output logic [31:0] res
);
  // Square root: 32 steps of the restoring digit loop on a 64-bit radicand.
  // Divide: 46-bit numerator (<2^45) by den, 46 steps of long division.
  logic        busy;
  logic [5:0]  cnt;
  logic        mode;
  logic [63:0] rem;
  logic [63:0] val;
  logic [31:0] root;
  logic [46:0] quo;
  logic [33:0] trial;
  logic [33:0] rsq;
  logic [32:0] dsub;

  assign trial = {rem[31:0], val[63:62]} - {root, 2'b01};
  assign dsub  = {rem[31:0], val[45]} - {1'b0, den};
  assign rsq   = {rem[31:0], val[63:62]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mode <= is_div;
        val  <= num;
        rem  <= 64'd0;
        root <= 32'd0;
        quo  <= 47'd0;
        cnt  <= is_div ? 6'd45 : 6'd31;
      end else if (busy) begin
        if (!mode) begin
          // Bring down two radicand bits, try the next root bit.
          val <= {val[61:0], 2'b00};
          if (!trial[33]) begin
            rem  <= {30'd0, trial};
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= {30'd0, rsq};
            root <= {root[30:0], 1'b0};
          end
        end else begin
          val <= {val[62:0], 1'b0};
          if (!dsub[32]) begin
            rem <= {31'd0, dsub};
            quo <= {quo[45:0], 1'b1};
          end else begin
            rem <= {31'd0, rem[31:0], val[45]};
            quo <= {quo[45:0], 1'b0};
          end
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  // Quotients used here stay below 2^32; the caller caps direction terms.
  always_comb begin
    if (mode) res = quo[31:0];
    else      res = root;
  end
endmodule
`default_nettype wire
